/* hw/rtl/pli_pkg.sv */
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants for the piecewise linear interpolation table.
// ----------------------------------------------------------------------------
package pli_pkg;

    // Table geometry and word widths.
    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int DATA_W     = 32;
    localparam int TOL_W      = 16;
    localparam int CFG_W      = 16;

    // Function codes of an input word.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Status codes of a result word.
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_RANGE      = 2'd1;
    localparam logic [1:0] STATUS_ZERO_WIDTH = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_POINT_COUNT = 1'b0;
    localparam logic CFG_EDGE_TOL    = 1'b1;

    // Input word.
    typedef struct packed {
        logic                     func;
        logic [IDX_W-1:0]         point_index;
        logic signed [DATA_W-1:0] x_value;
        logic signed [DATA_W-1:0] y_value;
    } pli_in_t;

    // Result word.
    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [1:0]               status;
    } pli_out_t;

endpackage

/* hw/rtl/piecewise_linear_interpolate.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_interpolate
// Breakpoint table with a sequential segment scan and a serial divider.
// ----------------------------------------------------------------------------
// A breakpoint write gives no result; busy stays low. A query with two or
// more points in use (at most 16) holds busy high until its result is shown:
// the table sits in one memory with a single read port and is scanned one
// entry per cycle, then one 32x32 multiply and a 32-step restoring divider
// (one quotient bit per cycle) produce the interpolated value. A query with
// fewer than two points returns in the cycle after it is taken. Each result
// word is shown for exactly one cycle with result_valid high and cannot be
// held off by the receiver.
module piecewise_linear_interpolate (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  pli_pkg::pli_in_t   item,
    output logic               result_valid,
    output pli_pkg::pli_out_t  result,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [pli_pkg::CFG_W-1:0] cfg_data
);
    import pli_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_EVAL  = 4'd2;
    localparam logic [3:0] S_EDGE1 = 4'd3;
    localparam logic [3:0] S_PREP  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_DIVI  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    localparam int DW = DATA_W;

    // Breakpoint memory: x in the upper half, y in the lower half.
    logic [2*DW-1:0] mem [MAX_POINTS];
    logic [2*DW-1:0] rd_data_reg;

    // Control registers.
    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0] rd_pos_reg, rd_pos_next;
    logic             found_reg, found_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             result_valid_reg, result_valid_next;
    logic [CNT_W-1:0] point_count_reg;
    logic [TOL_W-1:0] edge_tol_reg;

    // Payload registers.
    logic signed [DW-1:0] q_reg, q_next;
    logic signed [DW-1:0] first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic signed [DW-1:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic signed [DW-1:0] x0_reg, x0_next, x1_reg, x1_next;
    logic signed [DW-1:0] y0_reg, y0_next, y1_reg, y1_next;
    logic [DW-1:0]        dx_reg, dx_next, off_reg, off_next, dyabs_reg, dyabs_next;
    logic                 dyneg_reg, dyneg_next;
    logic [2*DW-1:0]      prod_reg, prod_next;
    logic [DW-1:0]        rem_reg, rem_next, lo_reg, lo_next;
    pli_out_t             result_reg, result_next;

    // Combinational helpers.
    logic                 accept;
    logic [CNT_W-1:0]     count_cap;
    logic signed [DW-1:0] cur_x, cur_y;
    logic signed [DW:0]   edge_diff;
    logic [DW:0]          edge_abs;
    logic signed [DW:0]   dy_full;
    logic [DW:0]          dy_mag;
    logic [2*DW-1:0]      dividend;
    logic [DW:0]          trial, trial_diff;
    logic                 trial_ge;
    logic signed [DW+1:0] final_sum;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign cur_x  = rd_data_reg[2*DW-1:DW];
    assign cur_y  = rd_data_reg[DW-1:0];

    // Table memory: written by a write word, read one entry per cycle.
    always_ff @(posedge clk)
    begin
        if (accept && item.func == FUNC_WRITE)
        begin
            mem[item.point_index] <= {item.x_value, item.y_value};
        end
        rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
    end

    // Datapath helpers shared across sequencer steps.
    always_comb
    begin
        count_cap = (point_count_reg > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                             : point_count_reg;
        if (state_reg == S_EDGE1)
        begin
            edge_diff = {q_reg[DW-1], q_reg} - {prev_x_reg[DW-1], prev_x_reg};
        end
        else
        begin
            edge_diff = {q_reg[DW-1], q_reg} - {first_x_reg[DW-1], first_x_reg};
        end
        edge_abs   = edge_diff[DW] ? (DW+1)'(-edge_diff) : edge_diff;
        dy_full    = {y1_reg[DW-1], y1_reg} - {y0_reg[DW-1], y0_reg};
        dy_mag     = dy_full[DW] ? (DW+1)'(-dy_full) : dy_full;
        dividend   = prod_reg + {(DW+1)'(0), dx_reg[DW-1:1]};
        trial      = {rem_reg, lo_reg[DW-1]};
        trial_diff = trial - {1'b0, dx_reg};
        trial_ge   = (trial >= {1'b0, dx_reg});
        if (dyneg_reg)
        begin
            final_sum = {{2{y0_reg[DW-1]}}, y0_reg} - {2'b00, lo_reg};
        end
        else
        begin
            final_sum = {{2{y0_reg[DW-1]}}, y0_reg} + {2'b00, lo_reg};
        end
    end

    // Sequencer and next-state logic.
    always_comb
    begin
        state_next        = state_reg;
        n_next            = n_reg;
        idx_next          = idx_reg;
        rd_valid_next     = 1'b0;
        rd_pos_next       = rd_pos_reg;
        found_next        = found_reg;
        cnt_next          = cnt_reg;
        result_valid_next = 1'b0;
        q_next            = q_reg;
        first_x_next      = first_x_reg;
        first_y_next      = first_y_reg;
        prev_x_next       = prev_x_reg;
        prev_y_next       = prev_y_reg;
        x0_next           = x0_reg;
        x1_next           = x1_reg;
        y0_next           = y0_reg;
        y1_next           = y1_reg;
        dx_next           = dx_reg;
        off_next          = off_reg;
        dyabs_next        = dyabs_reg;
        dyneg_next        = dyneg_reg;
        prod_next         = prod_reg;
        rem_next          = rem_reg;
        lo_next           = lo_reg;
        result_next       = result_reg;

        case (state_reg)
            S_IDLE:
            begin
                idx_next   = '0;
                found_next = 1'b0;
                if (accept && item.func == FUNC_QUERY)
                begin
                    q_next = item.x_value;
                    n_next = count_cap;
                    if (count_cap < CNT_W'(2))
                    begin
                        result_next.result_value = '0;
                        result_next.status       = STATUS_RANGE;
                        result_valid_next        = 1'b1;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue one read per cycle; check the entry read last cycle.
                if (idx_reg < n_reg)
                begin
                    rd_valid_next = 1'b1;
                    rd_pos_next   = idx_reg[IDX_W-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                end
                if (rd_valid_reg)
                begin
                    if (rd_pos_reg == '0)
                    begin
                        first_x_next = cur_x;
                        first_y_next = cur_y;
                    end
                    else if (prev_x_reg <= q_reg && cur_x >= q_reg)
                    begin
                        found_next = 1'b1;
                        x0_next    = prev_x_reg;
                        y0_next    = prev_y_reg;
                        x1_next    = cur_x;
                        y1_next    = cur_y;
                    end
                    prev_x_next = cur_x;
                    prev_y_next = cur_y;
                    if ({1'b0, rd_pos_reg} == n_reg - CNT_W'(1))
                    begin
                        state_next = S_EVAL;
                    end
                end
            end

            S_EVAL:
            begin
                if (found_reg)
                begin
                    if (x1_reg == x0_reg)
                    begin
                        result_next.result_value = '0;
                        result_next.status       = STATUS_ZERO_WIDTH;
                        result_valid_next        = 1'b1;
                        state_next               = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_PREP;
                    end
                end
                else if (edge_abs <= {(DW+1-TOL_W)'(0), edge_tol_reg})
                begin
                    result_next.result_value = first_y_reg;
                    result_next.status       = STATUS_OK;
                    result_valid_next        = 1'b1;
                    state_next               = S_IDLE;
                end
                else
                begin
                    state_next = S_EDGE1;
                end
            end

            S_EDGE1:
            begin
                // Previous entry now holds the last point of the table.
                if (edge_abs <= {(DW+1-TOL_W)'(0), edge_tol_reg})
                begin
                    result_next.result_value = prev_y_reg;
                    result_next.status       = STATUS_OK;
                end
                else
                begin
                    result_next.result_value = '0;
                    result_next.status       = STATUS_RANGE;
                end
                result_valid_next = 1'b1;
                state_next        = S_IDLE;
            end

            S_PREP:
            begin
                dx_next    = x1_reg - x0_reg;
                off_next   = q_reg - x0_reg;
                dyneg_next = dy_full[DW];
                dyabs_next = dy_mag[DW-1:0];
                state_next = S_MUL;
            end

            S_MUL:
            begin
                prod_next  = off_reg * dyabs_reg;
                state_next = S_DIVI;
            end

            S_DIVI:
            begin
                // Quotient fits 32 bits, so the upper half starts below dx.
                rem_next   = dividend[2*DW-1:DW];
                lo_next    = dividend[DW-1:0];
                cnt_next   = 5'd31;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                // One restoring step: quotient bits shift into lo_reg.
                rem_next = trial_ge ? trial_diff[DW-1:0] : trial[DW-1:0];
                lo_next  = {lo_reg[DW-2:0], trial_ge};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                // Apply the sign of dy and saturate to 32 bits.
                if (final_sum > (DW+2)'(signed'({1'b0, {(DW-1){1'b1}}})))
                begin
                    result_next.result_value = {1'b0, {(DW-1){1'b1}}};
                end
                else if (final_sum < (DW+2)'(signed'({1'b1, {(DW-1){1'b0}}})))
                begin
                    result_next.result_value = {1'b1, {(DW-1){1'b0}}};
                end
                else
                begin
                    result_next.result_value = final_sum[DW-1:0];
                end
                result_next.status = STATUS_OK;
                result_valid_next  = 1'b1;
                state_next         = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state with asynchronous reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            n_reg            <= '0;
            idx_reg          <= '0;
            rd_valid_reg     <= 1'b0;
            rd_pos_reg       <= '0;
            found_reg        <= 1'b0;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
            point_count_reg  <= '0;
            edge_tol_reg     <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            n_reg            <= n_next;
            idx_reg          <= idx_next;
            rd_valid_reg     <= rd_valid_next;
            rd_pos_reg       <= rd_pos_next;
            found_reg        <= found_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
            if (cfg_wr_en && cfg_index == CFG_POINT_COUNT)
            begin
                point_count_reg <= cfg_data[CNT_W-1:0];
            end
            if (cfg_wr_en && cfg_index == CFG_EDGE_TOL)
            begin
                edge_tol_reg <= cfg_data[TOL_W-1:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        q_reg       <= q_next;
        first_x_reg <= first_x_next;
        first_y_reg <= first_y_next;
        prev_x_reg  <= prev_x_next;
        prev_y_reg  <= prev_y_next;
        x0_reg      <= x0_next;
        x1_reg      <= x1_next;
        y0_reg      <= y0_next;
        y1_reg      <= y1_next;
        dx_reg      <= dx_next;
        off_reg     <= off_next;
        dyabs_reg   <= dyabs_next;
        dyneg_reg   <= dyneg_next;
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        lo_reg      <= lo_next;
        result_reg  <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A result word only follows a query that was taken or work in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy || (start && item.func == FUNC_QUERY)))
        else $error("result word without a query");

    // Any error status carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != STATUS_OK) |-> result.result_value == '0)
        else $error("nonzero value with error status");

    // A breakpoint write never starts the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.func == FUNC_WRITE) |=> !busy)
        else $error("write word made the block busy");

    // The divider remainder stays below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> rem_reg < dx_reg)
        else $error("divider remainder out of range");

endmodule
